// ===== rtl/rce_pkg.sv =====
package rce_pkg;

  localparam int ROWS   = 16;
  localparam int ROW_W  = ROWS;
  localparam int IDX_W  = $clog2(ROWS);
  localparam int SIZE_W = IDX_W + 1;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SIZE_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 1'b1;

  // Result selection.
  localparam logic [MODE_W-1:0] MODE_REACH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MUTUAL = 2'd2;

  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_INIT  = 3'd2,
    OP_PASS  = 3'd3,
    OP_REFL  = 3'd4,
    OP_MUT   = 3'd5,
    OP_SHIFT = 3'd6
  } cell_op_e;

  // Control word broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e           op;
    logic [IDX_W-1:0]   k;
    logic [IDX_W-1:0]   load_idx;
    logic [ROW_W-1:0]   load_row;
    logic [ROW_W-1:0]   mask;
    logic [SIZE_W-1:0]  n;
    logic               reflexive;
    logic               mutual;
    logic [ROW_W-1:0]   pivot;
  } cell_ctrl_t;

endpackage

// ===== rtl/rce_ifs.sv =====
interface rce_row_if import rce_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_bits;

  modport source (output valid, output row_bits, input ready);
  modport sink (input valid, input row_bits, output ready);
endinterface

interface rce_res_if import rce_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] row_index;
  logic [ROW_W-1:0] result_row;
  logic             last_row;

  modport source (output valid, output row_index, output result_row, output last_row,
                  input ready);
  modport sink (input valid, input row_index, input result_row, input last_row,
                output ready);
endinterface

// ===== rtl/relation_closure_engine.sv =====
// Relation closure engine.
// The row channel takes one 16-bit matrix row per transaction, row 0 first.
// Once n rows are in (n from the size register, clamped to 1..16), the block
// computes the transitive closure, reflexive reach or mutual reach, as chosen
// by the mode register, and sends n result transactions on the result channel,
// row 0 first, with last_row set on row n-1.
// Rows load at one per cycle while valid is high. After the transaction of
// the final row the block runs a masking step, 16 Warshall passes over a ring
// of 16 row cells (one pass per cycle, independent of n), the reflexive step
// and the mutual step; results then leave at one per cycle while the receiver
// takes them. The row channel is not ready while a matrix is being computed
// or sent.
// A stalled receiver simply holds the current result row; nothing is lost.
// Reset sets the mode to transitive closure and the size to 16 and empties
// the load counter; the row cells themselves are not cleared.
// Configuration writes take effect at once and belong between matrices.
module relation_closure_engine import rce_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rce_row_if.sink               row_i,
  rce_res_if.source             res_o
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_PASS = 3'd2;
  localparam logic [2:0] S_REFL = 3'd3;
  localparam logic [2:0] S_MUT  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [MODE_W-1:0] mode_q;
  logic [SIZE_W-1:0] size_q;
  logic [IDX_W-1:0]  load_cnt_q, load_cnt_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [IDX_W-1:0]  emit_cnt_q, emit_cnt_d;

  logic [SIZE_W-1:0] n;
  logic [ROW_W-1:0]  mask;
  logic              in_hs, out_hs, load_done, emit_last;
  cell_op_e          cell_op;
  cell_ctrl_t        ctrl;
  logic [ROW_W-1:0]  rows [ROWS];
  logic [ROW_W-1:0]  cols [ROWS];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      size_q <= SIZE_W'(ROWS);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
        CFG_SIZE: size_q <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (size_q == '0) begin
      n = SIZE_W'(1);
    end else if (size_q > SIZE_W'(ROWS)) begin
      n = SIZE_W'(ROWS);
    end else begin
      n = size_q;
    end
  end

  assign mask = ~({ROW_W{1'b1}} << n);

  assign row_i.ready = (state_q == S_LOAD);
  assign in_hs       = row_i.valid && row_i.ready;
  assign load_done   = (({1'b0, load_cnt_q} + SIZE_W'(1)) >= n);

  assign res_o.valid      = (state_q == S_EMIT);
  assign res_o.row_index  = emit_cnt_q;
  assign res_o.result_row = rows[0];
  assign emit_last        = (({1'b0, emit_cnt_q} + SIZE_W'(1)) == n);
  assign res_o.last_row   = emit_last;
  assign out_hs           = res_o.valid && res_o.ready;

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    k_d        = k_q;
    emit_cnt_d = emit_cnt_q;
    cell_op    = OP_HOLD;
    unique case (state_q)
      S_LOAD: begin
        if (in_hs) begin
          cell_op = OP_LOAD;
          if (load_done) begin
            load_cnt_d = '0;
            state_d    = S_INIT;
          end else begin
            load_cnt_d = load_cnt_q + IDX_W'(1);
          end
        end
      end
      S_INIT: begin
        cell_op = OP_INIT;
        k_d     = '0;
        state_d = S_PASS;
      end
      S_PASS: begin
        cell_op = OP_PASS;
        k_d     = k_q + IDX_W'(1);
        if (k_q == IDX_W'(ROWS - 1)) state_d = S_REFL;
      end
      S_REFL: begin
        cell_op = OP_REFL;
        state_d = S_MUT;
      end
      S_MUT: begin
        cell_op    = OP_MUT;
        emit_cnt_d = '0;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (out_hs) begin
          cell_op    = OP_SHIFT;
          emit_cnt_d = emit_cnt_q + IDX_W'(1);
          if (emit_last) state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_comb begin
    ctrl.op        = cell_op;
    ctrl.k         = k_q;
    ctrl.load_idx  = load_cnt_q;
    ctrl.load_row  = row_i.row_bits;
    ctrl.mask      = mask;
    ctrl.n         = n;
    ctrl.reflexive = (mode_q == MODE_REACH) || (mode_q == MODE_MUTUAL);
    ctrl.mutual    = (mode_q == MODE_MUTUAL);
    ctrl.pivot     = rows[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      load_cnt_q <= '0;
      k_q        <= '0;
      emit_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      k_q        <= k_d;
      emit_cnt_q <= emit_cnt_d;
    end
  end

  // Column c of the matrix, used by the mutual step in cell c.
  always_comb begin
    for (int c = 0; c < ROWS; c++) begin
      for (int j = 0; j < ROWS; j++) begin
        cols[c][j] = rows[j][c];
      end
    end
  end

  for (genvar c = 0; c < ROWS; c++) begin : g_cell
    rce_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .idx_i      (IDX_W'(c)),
      .next_row_i (rows[(c + 1) % ROWS]),
      .col_i      (cols[c]),
      .row_o      (rows[c])
    );
  end

  a_done_starts_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_hs && load_done) |=> (state_q == S_INIT && load_cnt_q == '0))
    else $error("completed load did not start the closure");

  a_init_clears_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |=> (state_q == S_PASS && k_q == '0))
    else $error("pass counter not cleared at closure start");

  a_full_pass_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PASS && k_q == IDX_W'(ROWS - 1)) |=> (state_q == S_REFL))
    else $error("pass sweep did not end after the last ring position");

  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_hs && emit_last) |=> (state_q == S_LOAD && row_i.ready))
    else $error("block did not return to loading after the last result row");

endmodule

// ===== rtl/rce_cell.sv =====
module rce_cell import rce_pkg::*; (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [ROW_W-1:0] next_row_i,
  input  logic [ROW_W-1:0] col_i,
  output logic [ROW_W-1:0] row_o
);

  logic [ROW_W-1:0] row_q, row_d;
  logic             in_range;
  logic [ROW_W-1:0] diag;

  assign in_range = ({1'b0, idx_i} < ctrl_i.n);
  assign diag     = ROW_W'(1) << idx_i;

  always_comb begin
    row_d = row_q;
    unique case (ctrl_i.op)
      OP_HOLD: ;
      OP_LOAD: begin
        if (ctrl_i.load_idx == idx_i) row_d = ctrl_i.load_row;
      end
      OP_INIT: row_d = in_range ? (row_q & ctrl_i.mask) : '0;
      // The ring rotates by one per pass, so the pivot row always sits in cell 0.
      OP_PASS: row_d = next_row_i | (next_row_i[ctrl_i.k] ? ctrl_i.pivot : '0);
      OP_REFL: begin
        if (ctrl_i.reflexive && in_range) row_d = row_q | diag;
      end
      OP_MUT: begin
        if (ctrl_i.mutual) row_d = row_q & col_i;
      end
      OP_SHIFT: row_d = next_row_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

  assign row_o = row_q;

endmodule
